FILE: sv/gcl_pkg.sv
// Shared types, codes and the exponent table of the cluster likelihood block.
`default_nettype none
package gcl_pkg;

   // item kinds
   localparam logic [1:0] KIND_LOAD   = 2'd0;
   localparam logic [1:0] KIND_SAMPLE = 2'd1;
   localparam logic [1:0] KIND_EMIT   = 2'd2;

   // register indexes
   localparam logic [2:0] CSR_BETA_0  = 3'd0;
   localparam logic [2:0] CSR_BETA_1  = 3'd1;
   localparam logic [2:0] CSR_BETA_2  = 3'd2;
   localparam logic [2:0] CSR_BETA_3  = 3'd3;
   localparam logic [2:0] CSR_NUM_COV = 3'd4;
   localparam logic [2:0] CSR_NUM_CLU = 3'd5;

   localparam int COV_FIELDS = 4;
   localparam logic [3:0] EXP_LAST = 4'd12;

   typedef struct packed {
      logic       take;
      logic       load_wr;
      logic       gene_rd;
      logic       cov_init;
      logic       cov_step;
      logic [1:0] cov_idx;
      logic       res;
      logic       sq;
      logic       gene_wr;
      logic       emit_lat;
      logic       clu_rd;
      logic       p1;
      logic       p2;
      logic       qc;
      logic       xc;
      logic       exp_step;
      logic [3:0] exp_idx;
      logic       wload;
   } gcl_cmd_type;

   typedef struct packed {
      logic gene_ok;
      logic clu_ok;
      logic out_free;
      logic clu_last;
      logic n_zero;
   } gcl_sts_type;

   // exp(-2^(k-8)) in Q0.32
   function automatic logic [31:0] exp_tab(input logic [3:0] k);
      logic [31:0] v;
      unique case (k)
         4'd0:    v = 32'd4278222810;
         4'd1:    v = 32'd4261543600;
         4'd2:    v = 32'd4228380020;
         4'd3:    v = 32'd4162825050;
         4'd4:    v = 32'd4034748390;
         4'd5:    v = 32'd3790295330;
         4'd6:    v = 32'd3344923900;
         4'd7:    v = 32'd2605029347;
         4'd8:    v = 32'd1580030169;
         4'd9:    v = 32'd581260610;
         4'd10:   v = 32'd78665070;
         4'd11:   v = 32'd1440801;
         4'd12:   v = 32'd483;
         default: v = 32'd0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/gcl_ctrl.sv
// Sequencer of the cluster likelihood block.
`default_nettype none
module gcl_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_kind,
   input  wire logic [2:0]          num_cov,
   input  wire gcl_pkg::gcl_sts_type sts,
   output logic                     req_stall,
   output gcl_pkg::gcl_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_COV, ST_RES, ST_SQ, ST_WR, ST_ELAT, ST_CRD,
      ST_P1, ST_P2, ST_Q, ST_X, ST_EXP, ST_W
   } state_type;

   state_type  state_ff, state_in;
   logic [2:0] cov_k_ff, cov_k_in;
   logic [3:0] exp_k_ff, exp_k_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      cov_k_in = cov_k_ff;
      exp_k_in = exp_k_ff;
      cmd.cov_idx = cov_k_ff[1:0];
      cmd.exp_idx = exp_k_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               priority if (req_kind == gcl_pkg::KIND_LOAD) begin
                  cmd.load_wr = sts.clu_ok;
               end else if (req_kind == gcl_pkg::KIND_SAMPLE && sts.gene_ok) begin
                  cmd.gene_rd  = 1'b1;
                  cmd.cov_init = 1'b1;
                  cov_k_in     = 3'd0;
                  state_in     = ST_COV;
               end else if (req_kind == gcl_pkg::KIND_EMIT && sts.gene_ok) begin
                  cmd.gene_rd = 1'b1;
                  state_in    = ST_ELAT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_COV: begin
            if (cov_k_ff < num_cov) begin
               cmd.cov_step = 1'b1;
               cov_k_in     = cov_k_ff + 3'd1;
            end else begin
               state_in = ST_RES;
            end
         end
         ST_RES: begin
            cmd.res  = 1'b1;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            cmd.sq   = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.gene_wr = 1'b1;
            state_in    = ST_IDLE;
         end
         ST_ELAT: begin
            cmd.emit_lat = 1'b1;
            state_in     = sts.n_zero ? ST_IDLE : ST_CRD;
         end
         ST_CRD: begin
            cmd.clu_rd = 1'b1;
            state_in   = ST_P1;
         end
         ST_P1: begin
            cmd.p1   = 1'b1;
            state_in = ST_P2;
         end
         ST_P2: begin
            cmd.p2   = 1'b1;
            state_in = ST_Q;
         end
         ST_Q: begin
            cmd.qc   = 1'b1;
            state_in = ST_X;
         end
         ST_X: begin
            cmd.xc   = 1'b1;
            exp_k_in = 4'd0;
            state_in = ST_EXP;
         end
         ST_EXP: begin
            cmd.exp_step = 1'b1;
            if (exp_k_ff == gcl_pkg::EXP_LAST) begin
               state_in = ST_W;
            end else begin
               exp_k_in = exp_k_ff + 4'd1;
            end
         end
         ST_W: begin
            // hold until the output register frees up
            if (sts.out_free) begin
               cmd.wload = 1'b1;
               state_in  = sts.clu_last ? ST_IDLE : ST_CRD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cov_k_ff <= 3'd0;
         exp_k_ff <= 4'd0;
      end else begin
         state_ff <= state_in;
         cov_k_ff <= cov_k_in;
         exp_k_ff <= exp_k_in;
      end
   end

endmodule
`default_nettype wire

FILE: sv/gcl_dp.sv
// Datapath of the cluster likelihood block: statistics, cluster table, arithmetic.
`default_nettype none
module gcl_dp #(
   parameter int MAX_GENES    = 64,
   parameter int MAX_CLUSTERS = 16,
   localparam int NW = $clog2(MAX_CLUSTERS + 1)
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire gcl_pkg::gcl_cmd_type cmd,
   output gcl_pkg::gcl_sts_type      sts,
   input  wire logic [NW-1:0]        num_clu,
   input  wire logic signed [15:0]   beta [gcl_pkg::COV_FIELDS],
   input  wire logic [5:0]           req_gene,
   input  wire logic [3:0]           req_cluster,
   input  wire logic signed [15:0]   req_value,
   input  wire logic [16:0]          req_stick,
   input  wire logic signed [15:0]   req_cov_0,
   input  wire logic signed [15:0]   req_cov_1,
   input  wire logic signed [15:0]   req_cov_2,
   input  wire logic signed [15:0]   req_cov_3,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [5:0]                rsp_out_gene,
   output logic [3:0]                rsp_out_cluster,
   output logic [31:0]               rsp_weight,
   output logic                      rsp_last
);

   localparam int GENE_DEPTH = (MAX_GENES < 64) ? MAX_GENES : 64;
   localparam int GAW = (GENE_DEPTH > 1) ? $clog2(GENE_DEPTH) : 1;
   localparam int CL_DEPTH = (MAX_CLUSTERS < 16) ? MAX_CLUSTERS : 16;
   localparam int CAW = (CL_DEPTH > 1) ? $clog2(CL_DEPTH) : 1;

   // gene statistics: {count, sum, sum of squares}
   logic [95:0]           gmem [GENE_DEPTH];
   logic [GENE_DEPTH-1:0] gvalid_ff;
   logic [95:0]           grd_ff;
   logic                  grd_valid_ff;
   // cluster table: {stick, mean}
   logic [32:0]           cmem [CL_DEPTH];
   logic [CL_DEPTH-1:0]   cvalid_ff;
   logic [32:0]           crd_ff;
   logic                  crd_valid_ff;

   logic [5:0]            gene_ff;
   logic signed [15:0]    cov_ff [gcl_pkg::COV_FIELDS];
   logic signed [35:0]    r24_ff;
   logic signed [23:0]    r_ff;
   logic [47:0]           sq_ff;
   logic [NW-1:0]         c_ff;
   logic signed [47:0]    p1_ff;
   logic [30:0]           tsq_ff;
   logic [46:0]           p2_ff;
   logic signed [51:0]    q_ff;
   logic [12:0]           x_ff;
   logic                  big_ff;
   logic [31:0]           acc_ff;
   logic                  one_ff;
   logic                  rsp_valid_ff;
   logic [5:0]            rsp_gene_ff;
   logic [3:0]            rsp_cluster_ff;
   logic [31:0]           rsp_weight_ff;
   logic                  rsp_last_ff;

   logic [15:0]           g_cnt;
   logic signed [31:0]    g_sum;
   logic [47:0]           g_sq;
   logic signed [15:0]    th;
   logic [16:0]           stick;
   logic signed [31:0]    cov_prod;
   logic signed [47:0]    r_sq;
   logic [15:0]           cnt_new;
   logic signed [32:0]    sum33;
   logic signed [31:0]    sum_new;
   logic [48:0]           sq49;
   logic [47:0]           sq_new;
   logic signed [31:0]    th_sq;
   logic signed [51:0]    s2_ext;
   logic signed [51:0]    p1_ext;
   logic signed [51:0]    p2_ext;
   logic [31:0]           tab_val;
   logic [63:0]           acc_mul;
   logic [32:0]           factor;
   logic [49:0]           wprod;
   logic [GAW-1:0]        gaddr;

   assign gaddr   = GAW'(gene_ff);
   assign g_cnt   = grd_valid_ff ? grd_ff[95:80] : 16'd0;
   assign g_sum   = grd_valid_ff ? $signed(grd_ff[79:48]) : 32'sd0;
   assign g_sq    = grd_valid_ff ? grd_ff[47:0] : 48'd0;
   assign th      = crd_valid_ff ? $signed(crd_ff[15:0]) : 16'sd0;
   assign stick   = crd_valid_ff ? crd_ff[32:16] : 17'd0;

   assign sts.gene_ok  = (req_gene < MAX_GENES);
   assign sts.clu_ok   = (req_cluster < MAX_CLUSTERS);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;
   assign sts.clu_last = ((NW+1)'(c_ff) + (NW+1)'(1)) == (NW+1)'(num_clu);
   assign sts.n_zero   = (num_clu == '0);

   // sample arithmetic
   assign cov_prod = cov_ff[cmd.cov_idx] * beta[cmd.cov_idx];
   assign r_sq     = r_ff * r_ff;
   assign cnt_new  = (g_cnt == 16'hFFFF) ? g_cnt : g_cnt + 16'd1;
   assign sum33    = 33'(g_sum) + 33'(r_ff);
   always_comb begin
      if (sum33[32] != sum33[31]) begin
         sum_new = sum33[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
         sum_new = sum33[31:0];
      end
   end
   assign sq49   = {1'b0, g_sq} + {1'b0, sq_ff};
   assign sq_new = sq49[48] ? 48'hFFFF_FFFF_FFFF : sq49[47:0];

   // emit arithmetic
   assign th_sq   = th * th;
   assign s2_ext  = $signed({4'd0, g_sq});
   assign p1_ext  = 52'(p1_ff);
   assign p2_ext  = $signed({5'd0, p2_ff});
   assign tab_val = gcl_pkg::exp_tab(cmd.exp_idx);
   assign acc_mul = acc_ff * tab_val;
   assign factor  = big_ff ? 33'd0 : {one_ff, acc_ff};
   assign wprod   = {33'd0, stick} * {17'd0, factor};

   // statistics memory
   always_ff @(posedge clock) begin
      if (cmd.gene_wr) begin
         gmem[gaddr] <= {cnt_new, sum_new, sq_new};
      end
      if (cmd.gene_rd) begin
         grd_ff <= gmem[GAW'(req_gene)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gvalid_ff    <= '0;
         grd_valid_ff <= 1'b0;
      end else begin
         if (cmd.gene_wr) begin
            gvalid_ff[gaddr] <= 1'b1;
         end
         if (cmd.emit_lat) begin
            gvalid_ff[gaddr] <= 1'b0;
         end
         if (cmd.gene_rd) begin
            grd_valid_ff <= gvalid_ff[GAW'(req_gene)];
         end
      end
   end

   // cluster memory
   always_ff @(posedge clock) begin
      if (cmd.load_wr) begin
         cmem[CAW'(req_cluster)] <= {req_stick, req_value};
      end
      if (cmd.clu_rd) begin
         crd_ff <= cmem[CAW'(c_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cvalid_ff    <= '0;
         crd_valid_ff <= 1'b0;
      end else begin
         if (cmd.load_wr) begin
            cvalid_ff[CAW'(req_cluster)] <= 1'b1;
         end
         if (cmd.clu_rd) begin
            crd_valid_ff <= (c_ff < CL_DEPTH) && cvalid_ff[CAW'(c_ff)];
         end
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         gene_ff   <= req_gene;
         cov_ff[0] <= req_cov_0;
         cov_ff[1] <= req_cov_1;
         cov_ff[2] <= req_cov_2;
         cov_ff[3] <= req_cov_3;
      end
      if (cmd.cov_init) begin
         r24_ff <= 36'(req_value) <<< 12;
      end
      if (cmd.cov_step) begin
         r24_ff <= r24_ff - 36'(cov_prod);
      end
      if (cmd.res) begin
         r_ff <= r24_ff[35:12];
      end
      if (cmd.sq) begin
         sq_ff <= $unsigned(r_sq);
      end
      if (cmd.p1) begin
         p1_ff  <= th * g_sum;
         tsq_ff <= th_sq[30:0];
      end
      if (cmd.p2) begin
         p2_ff <= {31'd0, g_cnt} * {16'd0, tsq_ff};
      end
      if (cmd.qc) begin
         q_ff <= s2_ext - (p1_ext <<< 1) + p2_ext;
      end
      if (cmd.xc) begin
         x_ff   <= q_ff[51] ? 13'd0 : q_ff[29:17];
         big_ff <= !q_ff[51] && (|q_ff[50:30]);
         acc_ff <= 32'd0;
         one_ff <= 1'b1;
      end
      if (cmd.exp_step && x_ff[cmd.exp_idx]) begin
         acc_ff <= one_ff ? tab_val : acc_mul[63:32];
         one_ff <= 1'b0;
      end
      if (cmd.wload) begin
         rsp_gene_ff    <= gene_ff;
         rsp_cluster_ff <= 4'(c_ff);
         rsp_weight_ff  <= (|wprod[49:48]) ? 32'hFFFF_FFFF : wprod[47:16];
         rsp_last_ff    <= sts.clu_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         c_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.emit_lat) begin
            c_ff <= '0;
         end else if (cmd.wload) begin
            c_ff <= c_ff + NW'(1);
         end
         if (cmd.wload) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_gene    = rsp_gene_ff;
   assign rsp_out_cluster = rsp_cluster_ff;
   assign rsp_weight      = rsp_weight_ff;
   assign rsp_last        = rsp_last_ff;

endmodule
`default_nettype wire

FILE: sv/gaussian_cluster_likelihood.sv
// Sample: one covariate product a cycle, then the residual, square and statistics write.
// Emit: read, clear, then per cluster: table read, products, 13-step exponent loop, result.
// Throughput: one word at a time; the input stalls until the current word is finished.
// Output waits in a register, so a stalled result delays the next cluster only.
// Reset (synchronous): configuration to defaults, valid bits of all stores cleared at once.
`default_nettype none
module gaussian_cluster_likelihood #(
   parameter int MAX_GENES      = 64,
   parameter int MAX_CLUSTERS   = 16,
   parameter int MAX_COVARIATES = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_kind,
   input  wire logic [5:0]         req_gene,
   input  wire logic [3:0]         req_cluster,
   input  wire logic signed [15:0] req_value,
   input  wire logic [16:0]        req_stick,
   input  wire logic signed [15:0] req_cov_0,
   input  wire logic signed [15:0] req_cov_1,
   input  wire logic signed [15:0] req_cov_2,
   input  wire logic signed [15:0] req_cov_3,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [5:0]              rsp_out_gene,
   output logic [3:0]              rsp_out_cluster,
   output logic [31:0]             rsp_weight,
   output logic                    rsp_last,
   input  wire logic               csr_we,
   input  wire logic [2:0]         csr_addr,
   input  wire logic [15:0]        csr_wdata
);

   localparam int NW = $clog2(MAX_CLUSTERS + 1);
   localparam int COV_LIM = (MAX_COVARIATES < gcl_pkg::COV_FIELDS) ?
                            MAX_COVARIATES : gcl_pkg::COV_FIELDS;

   logic signed [15:0]   beta_ff [gcl_pkg::COV_FIELDS];
   logic [2:0]           ncov_ff;
   logic [4:0]           nclu_ff;
   logic [2:0]           num_cov;
   logic [NW-1:0]        num_clu;
   gcl_pkg::gcl_cmd_type cmd;
   gcl_pkg::gcl_sts_type sts;

   // configuration registers; the user writes them only while the block is idle (not enforced)
   always_ff @(posedge clock) begin
      if (reset) begin
         beta_ff[0] <= 16'sd0;
         beta_ff[1] <= 16'sd0;
         beta_ff[2] <= 16'sd0;
         beta_ff[3] <= 16'sd0;
         ncov_ff    <= 3'd0;
         nclu_ff    <= 5'd16;
      end else if (csr_we) begin
         unique case (csr_addr)
            gcl_pkg::CSR_BETA_0:  beta_ff[0] <= $signed(csr_wdata);
            gcl_pkg::CSR_BETA_1:  beta_ff[1] <= $signed(csr_wdata);
            gcl_pkg::CSR_BETA_2:  beta_ff[2] <= $signed(csr_wdata);
            gcl_pkg::CSR_BETA_3:  beta_ff[3] <= $signed(csr_wdata);
            gcl_pkg::CSR_NUM_COV: ncov_ff    <= csr_wdata[2:0];
            gcl_pkg::CSR_NUM_CLU: nclu_ff    <= csr_wdata[4:0];
            default:              ;  // drop writes beyond the register list
         endcase
      end
   end

   // clamp the counts to what the build supports
   assign num_cov = (int'(ncov_ff) > COV_LIM) ? 3'(COV_LIM) : ncov_ff;
   assign num_clu = (int'(nclu_ff) > MAX_CLUSTERS) ? NW'(MAX_CLUSTERS) : NW'(nclu_ff);

   gcl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .num_cov   (num_cov),
      .sts       (sts),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   gcl_dp #(
      .MAX_GENES    (MAX_GENES),
      .MAX_CLUSTERS (MAX_CLUSTERS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .num_clu         (num_clu),
      .beta            (beta_ff),
      .req_gene        (req_gene),
      .req_cluster     (req_cluster),
      .req_value       (req_value),
      .req_stick       (req_stick),
      .req_cov_0       (req_cov_0),
      .req_cov_1       (req_cov_1),
      .req_cov_2       (req_cov_2),
      .req_cov_3       (req_cov_3),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_gene    (rsp_out_gene),
      .rsp_out_cluster (rsp_out_cluster),
      .rsp_weight      (rsp_weight),
      .rsp_last        (rsp_last)
   );

   // a result word is only loaded when the output register can take it
   a_wload_free: assert property (@(posedge clock) disable iff (reset)
      cmd.wload |-> sts.out_free)
      else $error("result loaded over a pending word");

   // datapath steps never overlap
   a_one_step: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.take, cmd.cov_step, cmd.exp_step, cmd.wload, cmd.clu_rd, cmd.gene_wr}))
      else $error("overlapping datapath commands");

   // an emit with no clusters returns to idle right after clearing
   a_empty_emit: assert property (@(posedge clock) disable iff (reset)
      cmd.emit_lat && sts.n_zero |=> !req_stall)
      else $error("empty emit did not finish");

endmodule
`default_nettype wire
